// File: src/wsfd_pkg.sv
package wsfd_pkg;

    // Parser phases
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_EXTLEN  = 2'd1,
        PH_KEY     = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    // Link state
    typedef enum logic [1:0] {
        LINK_OPEN   = 2'd0,
        LINK_CLOSED = 2'd2
    } link_t;

    // Event kinds on the result side
    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_BINARY = 2'd1;
    localparam logic [1:0] KIND_PING   = 2'd2;
    localparam logic [1:0] KIND_CLOSE  = 2'd3;

    // Frame opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    // Length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;

    // Synthesized close codes
    localparam logic [15:0] CODE_NONE        = 16'd0;
    localparam logic [15:0] CODE_EMPTY_CLOSE = 16'd1005;
    localparam logic [15:0] CODE_LINK_LOST   = 16'd1006;

    // Input function codes
    localparam logic FUNC_BYTE      = 1'b0;
    localparam logic FUNC_LINK_LOST = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pbyte;
        logic        byte_valid;
        logic        last;
        logic        fin;
        logic [15:0] code;
        logic        reply;
    } result_t;

    // Kind of a frame: bit 2 set if the frame is passed on, bits 1:0 the kind
    function automatic logic [2:0] kind_of(input logic [3:0] op);
        logic [2:0] k;
        case (op)
            OP_TEXT:   k = {1'b1, KIND_TEXT};
            OP_BINARY: k = {1'b1, KIND_BINARY};
            OP_PING:   k = {1'b1, KIND_PING};
            OP_CLOSE:  k = {1'b1, KIND_CLOSE};
            default:   k = 3'b000;
        endcase
        return k;
    endfunction

endpackage

// File: src/wsfd_parser.sv
module wsfd_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 func,
    input  logic [7:0]           data,
    output wsfd_pkg::result_t    res,
    output logic                 res_valid
);

    wsfd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       header_count_reg, header_count_next;
    logic [3:0]       frame_opcode_reg, frame_opcode_next;
    logic             fin_flag_reg, fin_flag_next;
    logic             masked_flag_reg, masked_flag_next;
    logic [6:0]       length_code_reg, length_code_next;
    logic [63:0]      remaining_len_reg, remaining_len_next;
    logic [31:0]      mask_word_reg, mask_word_next;
    logic [1:0]       mask_index_reg, mask_index_next;
    wsfd_pkg::link_t  link_state_reg, link_state_next;

    logic [2:0]  kind_info;
    logic [3:0]  count_inc;
    logic        hdr_end;
    logic [63:0] rem_dec;
    logic        pay_last;
    logic [7:0]  key_byte;

    assign kind_info = wsfd_pkg::kind_of(frame_opcode_reg);
    assign count_inc = header_count_reg + 4'd1;
    assign rem_dec   = remaining_len_reg - 64'd1;
    assign pay_last  = (rem_dec == 64'd0);

    always_comb
    begin
        case (mask_index_reg)
            2'd0:    key_byte = mask_word_reg[31:24];
            2'd1:    key_byte = mask_word_reg[23:16];
            2'd2:    key_byte = mask_word_reg[15:8];
            default: key_byte = mask_word_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        frame_opcode_next  = frame_opcode_reg;
        fin_flag_next      = fin_flag_reg;
        masked_flag_next   = masked_flag_reg;
        length_code_next   = length_code_reg;
        remaining_len_next = remaining_len_reg;
        mask_word_next     = mask_word_reg;
        mask_index_next    = mask_index_reg;
        link_state_next    = link_state_reg;
        hdr_end            = 1'b0;
        res_valid          = 1'b0;
        res                = '0;

        if (func == wsfd_pkg::FUNC_LINK_LOST)
        begin
            phase_next        = wsfd_pkg::PH_HEADER;
            header_count_next = 4'd0;
            if (link_state_reg != wsfd_pkg::LINK_CLOSED)
            begin
                link_state_next = wsfd_pkg::LINK_CLOSED;
                res_valid       = 1'b1;
                res.kind        = wsfd_pkg::KIND_CLOSE;
                res.last        = 1'b1;
                res.fin         = 1'b1;
                res.code        = wsfd_pkg::CODE_LINK_LOST;
            end
        end
        else if (link_state_reg != wsfd_pkg::LINK_CLOSED)
        begin
            case (phase_reg)
                wsfd_pkg::PH_HEADER:
                begin
                    if (header_count_reg == 4'd0)
                    begin
                        fin_flag_next     = data[7];
                        frame_opcode_next = data[3:0];
                        header_count_next = 4'd1;
                    end
                    else
                    begin
                        masked_flag_next  = data[7];
                        length_code_next  = data[6:0];
                        mask_word_next    = 32'd0;
                        mask_index_next   = 2'd0;
                        header_count_next = 4'd0;
                        if (data[6:0] < wsfd_pkg::LEN_EXT16)
                        begin
                            remaining_len_next = {57'd0, data[6:0]};
                            if (data[7])
                                phase_next = wsfd_pkg::PH_KEY;
                            else
                                hdr_end = 1'b1;
                        end
                        else
                        begin
                            remaining_len_next = 64'd0;
                            phase_next         = wsfd_pkg::PH_EXTLEN;
                        end
                    end
                end
                wsfd_pkg::PH_EXTLEN:
                begin
                    remaining_len_next = {remaining_len_reg[55:0], data};
                    header_count_next  = count_inc;
                    if (count_inc >= ((length_code_reg == wsfd_pkg::LEN_EXT16) ? 4'd2 : 4'd8))
                    begin
                        header_count_next = 4'd0;
                        if (masked_flag_reg)
                            phase_next = wsfd_pkg::PH_KEY;
                        else
                            hdr_end = 1'b1;
                    end
                end
                wsfd_pkg::PH_KEY:
                begin
                    mask_word_next    = {mask_word_reg[23:0], data};
                    header_count_next = count_inc;
                    if (count_inc >= 4'd4)
                        hdr_end = 1'b1;
                end
                default:
                begin
                    mask_index_next    = mask_index_reg + 2'd1;
                    remaining_len_next = rem_dec;
                    if (pay_last)
                    begin
                        phase_next        = wsfd_pkg::PH_HEADER;
                        header_count_next = 4'd0;
                    end
                    if (kind_info[2])
                    begin
                        res_valid      = 1'b1;
                        res.kind       = kind_info[1:0];
                        res.pbyte      = data ^ key_byte;
                        res.byte_valid = 1'b1;
                        res.last       = pay_last;
                        res.fin        = fin_flag_reg;
                        if (kind_info[1:0] == wsfd_pkg::KIND_CLOSE && pay_last)
                        begin
                            res.reply       = 1'b1;
                            link_state_next = wsfd_pkg::LINK_CLOSED;
                        end
                    end
                end
            endcase

            // Header complete: enter payload, or report an empty frame
            if (hdr_end)
            begin
                mask_index_next   = 2'd0;
                header_count_next = 4'd0;
                if (remaining_len_next != 64'd0)
                begin
                    phase_next = wsfd_pkg::PH_PAYLOAD;
                end
                else
                begin
                    phase_next = wsfd_pkg::PH_HEADER;
                    if (kind_info[2])
                    begin
                        res_valid = 1'b1;
                        res.kind  = kind_info[1:0];
                        res.last  = 1'b1;
                        res.fin   = fin_flag_reg;
                        if (kind_info[1:0] == wsfd_pkg::KIND_CLOSE)
                        begin
                            res.code        = wsfd_pkg::CODE_EMPTY_CLOSE;
                            res.reply       = 1'b1;
                            link_state_next = wsfd_pkg::LINK_CLOSED;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= wsfd_pkg::PH_HEADER;
            header_count_reg  <= 4'd0;
            frame_opcode_reg  <= 4'd0;
            fin_flag_reg      <= 1'b0;
            masked_flag_reg   <= 1'b0;
            length_code_reg   <= 7'd0;
            remaining_len_reg <= 64'd0;
            mask_word_reg     <= 32'd0;
            mask_index_reg    <= 2'd0;
            link_state_reg    <= wsfd_pkg::LINK_OPEN;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            frame_opcode_reg  <= frame_opcode_next;
            fin_flag_reg      <= fin_flag_next;
            masked_flag_reg   <= masked_flag_next;
            length_code_reg   <= length_code_next;
            remaining_len_reg <= remaining_len_next;
            mask_word_reg     <= mask_word_next;
            mask_index_reg    <= mask_index_next;
            link_state_reg    <= link_state_next;
        end
    end

endmodule

// File: src/websocket_frame_deframer_core.sv
// Channel | Handshake            | Payload
// --------+----------------------+-----------------------------------------------
// in      | in_valid / in_stall  | func, data_in
// out     | out_valid / out_stall| event_kind, payload_byte, byte_valid,
//         |                      | last_of_frame, final_fragment,
//         |                      | synth_close_code, reply_close
//
// One request per cycle sustained while out is not stalled. An accepted request
// waits in the input register and its result lands in the result register as it
// advances; the widest path there is the 64-bit length decrement and zero compare.
// rst_n clears both valid flags and puts the parser in header phase, link open.
// A stall on out holds the result register; in stalls only while the input
// register is full and cannot advance into the parser.
module websocket_frame_deframer_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  data_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [7:0]  payload_byte,
    output logic        byte_valid,
    output logic        last_of_frame,
    output logic        final_fragment,
    output logic [15:0] synth_close_code,
    output logic        reply_close
);

    // Input register
    logic              in_valid_reg;
    logic              func_reg;
    logic [7:0]        data_reg;

    // Result register
    logic              out_valid_reg, out_valid_next;
    wsfd_pkg::result_t res_reg;

    wsfd_pkg::result_t step_res;
    logic              step_res_valid;
    logic              step;
    logic              out_free;
    logic              in_take;

    // The result register can take a new request when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    // Advance the held request through the parser when its result has a place
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    wsfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .func      (func_reg),
        .data      (data_reg),
        .res       (step_res),
        .res_valid (step_res_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= func;
            data_reg <= data_in;
        end
    end

    // Load a new result, drop a delivered one, hold a stalled one
    always_comb
    begin
        if (step && step_res_valid)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && step_res_valid)
            res_reg <= step_res;
    end

    assign out_valid        = out_valid_reg;
    assign event_kind       = res_reg.kind;
    assign payload_byte     = res_reg.pbyte;
    assign byte_valid       = res_reg.byte_valid;
    assign last_of_frame    = res_reg.last;
    assign final_fragment   = res_reg.fin;
    assign synth_close_code = res_reg.code;
    assign reply_close      = res_reg.reply;

    // A reply close only ends a close frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_close |->
            event_kind == wsfd_pkg::KIND_CLOSE && last_of_frame)
        else $error("reply close on a result that does not end a close frame");

    // A synthesized close code never rides with a payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && synth_close_code != wsfd_pkg::CODE_NONE |->
            !byte_valid && last_of_frame && event_kind == wsfd_pkg::KIND_CLOSE)
        else $error("close code on a byte result");

    // The input side stalls only when a full input register meets a blocked output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without back pressure");

    // A stalled result is held unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_reg))
        else $error("stalled result changed");

endmodule
